// ===== hw/rtl/rta_pkg.sv =====
package rta_pkg;

   // Table geometry and field widths
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int ADDR_W          = 16;
   localparam int HOPS_W          = 16;
   localparam int STAMP_W         = 16;
   localparam int SEQ_W           = 32;
   localparam int FILL_W          = 6;
   localparam int CSR_IDX_W       = 8;
   localparam int CSR_DATA_W      = 16;

   // Register reset values
   localparam logic [15:0] LIFE_LIMIT_RST   = 16'd50;
   localparam logic [15:0] RENEW_PERIOD_RST = 16'd25;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIFE_LIMIT   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RENEW_PERIOD = 8'd1;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_LOOKUP  = 2'd1,
      CMD_REFRESH = 2'd2,
      CMD_TICK    = 2'd3
   } cmd_type;

   // One table entry as stored in memory
   typedef struct packed {
      logic [ADDR_W-1:0]  dest;
      logic [ADDR_W-1:0]  nxt;
      logic [HOPS_W-1:0]  hops;
      logic [STAMP_W-1:0] stamp;
      logic [SEQ_W-1:0]   seq;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic req_ready;
      logic load;
      logic scan;
      logic apply;
      logic emit;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic scan_done;
      logic out_free;
   } ctl_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_APPLY = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

endpackage

// ===== hw/rtl/rta_if.sv =====
// Request channel
interface rta_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] dst_node;
   logic [15:0] next_addr;
   logic [15:0] hops;
   logic [31:0] route_seq;

   modport source (output valid, command, dst_node, next_addr, hops, route_seq,
                   input ready);
   modport sink (input valid, command, dst_node, next_addr, hops, route_seq,
                 output ready);
endinterface

// Response channel
interface rta_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [15:0] next_hop;
   logic [15:0] hop_len;
   logic [31:0] stored_seq;
   logic [5:0]  fill_level;
   logic        full_drop;

   modport source (output valid, found, next_hop, hop_len, stored_seq, fill_level,
                   full_drop, input ready);
   modport sink (input valid, found, next_hop, hop_len, stored_seq, fill_level,
                 full_drop, output ready);
endinterface

// Register write channel
interface rta_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/rta_ctrl.sv =====
module rta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  rta_pkg::ctl_sts_type sts,
   output rta_pkg::ctl_cmd_type cmd
);

   rta_pkg::state_type state_ff, state_in;

   // Sequence one item: take it, scan the table, update, hand off the result
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         rta_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid) begin
               cmd.load = 1'b1;
               state_in = rta_pkg::ST_SCAN;
            end
         end
         rta_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = rta_pkg::ST_APPLY;
         end
         rta_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = rta_pkg::ST_OUT;
         end
         rta_pkg::ST_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = rta_pkg::ST_IDLE;
            end
         end
         default: state_in = rta_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rta_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/rta_datapath.sv =====
module rta_datapath #(
   parameter int TABLE_DEPTH = rta_pkg::TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rta_pkg::ctl_cmd_type cmd,
   output logic                 scan_done,
   output logic                 out_free,
   input  logic [1:0]           in_command,
   input  logic [15:0]          in_dest,
   input  logic [15:0]          in_next,
   input  logic [15:0]          in_hops,
   input  logic [31:0]          in_seq,
   rta_rsp_if.source            rsp,
   rta_csr_if.sink              csr
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // Table memory, one read and one write port
   rta_pkg::entry_type entry_mem [TABLE_DEPTH];
   rta_pkg::entry_type rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   rta_pkg::entry_type wr_data;

   // Configuration and global state
   logic [15:0]   life_ff, life_in;
   logic [15:0]   period_ff, period_in;
   logic [15:0]   time_ff, time_in;
   logic [15:0]   cd_ff, cd_in;
   logic [CW-1:0] slots_ff, slots_in;

   // Captured item
   rta_pkg::cmd_type op_ff;
   logic [15:0]      dest_ff, next_ff, hops_ff;
   logic [31:0]      seq_ff;
   logic             scan_en_ff, scan_en_in;

   // Scan pipeline and search results
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic               chk_vld_ff;
   logic [AW-1:0]      chk_idx_ff;
   logic               issue;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      hit_idx_ff, hit_idx_in;
   rta_pkg::entry_type hit_ent_ff, hit_ent_in;
   logic               empty_ff, empty_in;
   logic [AW-1:0]      empty_idx_ff, empty_idx_in;
   logic [15:0]        age;
   logic               shorter;

   // Result hold and output register
   logic        res_found_ff, res_found_in;
   logic [15:0] res_next_ff, res_next_in;
   logic [15:0] res_hops_ff, res_hops_in;
   logic [31:0] res_seq_ff, res_seq_in;
   logic        res_drop_ff, res_drop_in;
   logic        rsp_vld_ff, rsp_vld_in;

   assign csr.ready = 1'b1;
   assign issue     = cmd.scan && scan_en_ff && (rd_idx_ff < slots_ff);
   assign rd_addr   = rd_idx_ff[AW-1:0];
   assign scan_done = !(scan_en_ff && (rd_idx_ff < slots_ff)) && !chk_vld_ff;
   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign age       = time_ff - rd_data_ff.stamp;
   assign shorter   = hops_ff < hit_ent_ff.hops;

   // Register writes
   always_comb begin
      life_in   = life_ff;
      period_in = period_ff;
      if (csr.valid) begin
         if (csr.index == rta_pkg::CSR_LIFE_LIMIT)   life_in   = csr.wdata;
         if (csr.index == rta_pkg::CSR_RENEW_PERIOD) period_in = csr.wdata;
      end
   end

   // Capture the item; a tick advances time and the renew countdown at once
   always_comb begin
      time_in    = time_ff;
      cd_in      = cd_ff;
      scan_en_in = scan_en_ff;
      if (cmd.load) begin
         if (rta_pkg::cmd_type'(in_command) == rta_pkg::CMD_TICK) begin
            time_in = time_ff + 16'd1;
            if (cd_ff <= 16'd1) begin
               cd_in      = (period_ff == 16'd0) ? 16'd1 : period_ff;
               scan_en_in = 1'b1;
            end else begin
               cd_in      = cd_ff - 16'd1;
               scan_en_in = 1'b0;
            end
         end else begin
            scan_en_in = (in_dest != 16'd0);
         end
      end
   end

   // Scan: evaluate each entry in the cycle after its read; apply the add and set the result at the end
   always_comb begin
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_ent_in   = hit_ent_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      slots_in     = slots_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_data      = rd_data_ff;
      res_found_in = res_found_ff;
      res_next_in  = res_next_ff;
      res_hops_in  = res_hops_ff;
      res_seq_in   = res_seq_ff;
      res_drop_in  = res_drop_ff;

      if (cmd.load) begin
         rd_idx_in = '0;
         hit_in    = 1'b0;
         empty_in  = 1'b0;
      end
      if (issue) rd_idx_in = rd_idx_ff + CW'(1);

      if (chk_vld_ff) begin
         case (op_ff)
            rta_pkg::CMD_ADD: begin
               if (!hit_ff && rd_data_ff.dest == dest_ff && rd_data_ff.nxt == next_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_ent_in = rd_data_ff;
               end
               if (!empty_ff && rd_data_ff.dest == 16'd0) begin
                  empty_in     = 1'b1;
                  empty_idx_in = chk_idx_ff;
               end
            end
            rta_pkg::CMD_LOOKUP: begin
               if (!hit_ff && rd_data_ff.dest == dest_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_ent_in = rd_data_ff;
               end
            end
            rta_pkg::CMD_REFRESH: begin
               if (rd_data_ff.dest == dest_ff) begin
                  wr_en         = 1'b1;
                  wr_data.stamp = time_ff;
               end
            end
            rta_pkg::CMD_TICK: begin
               if (age > life_ff) begin
                  wr_en   = 1'b1;
                  wr_data = '0;
               end
            end
            default: ;
         endcase
      end

      if (cmd.apply) begin
         res_found_in = 1'b0;
         res_next_in  = '0;
         res_hops_in  = '0;
         res_seq_in   = '0;
         res_drop_in  = 1'b0;
         if (op_ff == rta_pkg::CMD_ADD && dest_ff != 16'd0) begin
            if (hit_ff) begin
               // Duplicate: keep the shorter route, keep the stored sequence
               res_found_in = 1'b1;
               res_next_in  = hit_ent_ff.nxt;
               res_seq_in   = hit_ent_ff.seq;
               res_hops_in  = shorter ? hops_ff : hit_ent_ff.hops;
               wr_en        = shorter;
               wr_addr      = hit_idx_ff;
               wr_data      = hit_ent_ff;
               wr_data.hops = hops_ff;
               wr_data.stamp = time_ff;
            end else begin
               wr_data.dest  = dest_ff;
               wr_data.nxt   = next_ff;
               wr_data.hops  = hops_ff;
               wr_data.stamp = time_ff;
               wr_data.seq   = seq_ff;
               if (empty_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = empty_idx_ff;
               end else if (slots_ff < DEPTH_C) begin
                  wr_en    = 1'b1;
                  wr_addr  = slots_ff[AW-1:0];
                  slots_in = slots_ff + CW'(1);
               end else begin
                  res_drop_in = 1'b1;
               end
            end
         end else if (op_ff == rta_pkg::CMD_LOOKUP && hit_ff) begin
            res_found_in = 1'b1;
            res_next_in  = hit_ent_ff.nxt;
            res_hops_in  = hit_ent_ff.hops;
            res_seq_in   = hit_ent_ff.seq;
         end
      end
   end

   // Output register: load on emit, drop once taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp.ready) rsp_vld_in = 1'b0;
      if (cmd.emit)  rsp_vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         life_ff    <= rta_pkg::LIFE_LIMIT_RST;
         period_ff  <= rta_pkg::RENEW_PERIOD_RST;
         time_ff    <= '0;
         cd_ff      <= rta_pkg::RENEW_PERIOD_RST;
         slots_ff   <= '0;
         scan_en_ff <= 1'b0;
         rd_idx_ff  <= '0;
         chk_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         empty_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         life_ff    <= life_in;
         period_ff  <= period_in;
         time_ff    <= time_in;
         cd_ff      <= cd_in;
         slots_ff   <= slots_in;
         scan_en_ff <= scan_en_in;
         rd_idx_ff  <= rd_idx_in;
         chk_vld_ff <= issue;
         hit_ff     <= hit_in;
         empty_ff   <= empty_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= rta_pkg::cmd_type'(in_command);
         dest_ff <= in_dest;
         next_ff <= in_next;
         hops_ff <= in_hops;
         seq_ff  <= in_seq;
      end
      chk_idx_ff   <= rd_addr;
      hit_idx_ff   <= hit_idx_in;
      hit_ent_ff   <= hit_ent_in;
      empty_idx_ff <= empty_idx_in;
      res_found_ff <= res_found_in;
      res_next_ff  <= res_next_in;
      res_hops_ff  <= res_hops_in;
      res_seq_ff   <= res_seq_in;
      res_drop_ff  <= res_drop_in;
      if (cmd.emit) begin
         rsp.found      <= res_found_ff;
         rsp.next_hop   <= res_next_ff;
         rsp.hop_len    <= res_hops_ff;
         rsp.stored_seq <= res_seq_ff;
         rsp.fill_level <= rta_pkg::FILL_W'(slots_ff);
         rsp.full_drop  <= res_drop_ff;
      end
   end

   assign rsp.valid = rsp_vld_ff;

endmodule

// ===== hw/rtl/route_table_with_aging_top.sv =====
// An accepted item passes through ST_SCAN, ST_APPLY and ST_OUT; the scan covers the N
// slots in use and is skipped when nothing is scanned (empty table, destination 0, or a
// tick without a sweep). A stalled receiver holds the response in the output register.
// A new item is taken only after ST_OUT has loaded the last response; the scan
// reads one entry per cycle through the single read port of the table memory.
// Reset (synchronous, active high) clears control, counters and time and loads the register
// defaults; the table is not cleared, slots past the fill count are never evaluated.
module route_table_with_aging_top #(
   parameter int TABLE_DEPTH = rta_pkg::TABLE_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   rta_req_if.sink   req_ch,
   rta_rsp_if.source rsp_ch,
   rta_csr_if.sink   csr_ch
);

   rta_pkg::ctl_cmd_type cmd;
   rta_pkg::ctl_sts_type sts;
   logic                 scan_done;
   logic                 out_free;

   assign req_ch.ready  = cmd.req_ready;
   assign sts.req_valid = req_ch.valid;
   assign sts.scan_done = scan_done;
   assign sts.out_free  = out_free;

   rta_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   rta_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .scan_done  (scan_done),
      .out_free   (out_free),
      .in_command (req_ch.command),
      .in_dest    (req_ch.dst_node),
      .in_next    (req_ch.next_addr),
      .in_hops    (req_ch.hops),
      .in_seq     (req_ch.route_seq),
      .rsp        (rsp_ch),
      .csr        (csr_ch)
   );

   // An accepted item closes the request side until its response is handed off
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while an item is in flight");

   // A response is loaded only into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("response overwritten before it was taken");

   // A dropped add never reports a match
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.full_drop && rsp_ch.found))
      else $error("drop and match reported together");

   // Without a match the reported route fields are zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.found) |->
         (rsp_ch.next_hop == 16'd0 && rsp_ch.hop_len == 16'd0 &&
          rsp_ch.stored_seq == 32'd0))
      else $error("route fields set without a match");

endmodule

// ===== bench/route_table_with_aging_top_test.sv =====
`timescale 1ns / 1ps

module route_table_with_aging_top_test;

   localparam int DEPTH         = rta_pkg::TABLE_DEPTH_DEF;
   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 10;
   localparam int DRAIN_SLACK   = DEPTH + 8;
   localparam int HOLD_CYCLES   = 600;
   localparam int WATCHDOG_NS   = 5_000_000 * CLK_PERIOD;

   // register indexes past the two implemented ones
   localparam logic [rta_pkg::CSR_IDX_W-1:0] CSR_SPARE_IDX = 8'd2;
   localparam logic [rta_pkg::CSR_IDX_W-1:0] CSR_LAST_IDX  = 8'hFF;

   typedef struct packed {
      rta_pkg::cmd_type            command;
      logic [rta_pkg::ADDR_W-1:0]  dst_node;
      logic [rta_pkg::ADDR_W-1:0]  next_addr;
      logic [rta_pkg::HOPS_W-1:0]  hops;
      logic [rta_pkg::SEQ_W-1:0]   route_seq;
   } route_req_type;

   typedef struct packed {
      logic                        found;
      logic [rta_pkg::ADDR_W-1:0]  next_hop;
      logic [rta_pkg::HOPS_W-1:0]  hop_len;
      logic [rta_pkg::SEQ_W-1:0]   stored_seq;
      logic [rta_pkg::FILL_W-1:0]  fill_level;
      logic                        full_drop;
   } route_rsp_type;

   typedef struct {
      route_req_type req;
      bit            typed;
      route_rsp_type rsp;
   } dir_row_type;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_MOSTLY
   } rx_pattern_type;

   logic clock = 1'b0;
   logic reset;

   rta_req_if req_ch ();
   rta_rsp_if rsp_ch ();
   rta_csr_if csr_ch ();

   route_table_with_aging_top #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // shadow copy of the route table
   logic [rta_pkg::ADDR_W-1:0]  tbl_dest  [DEPTH];
   logic [rta_pkg::ADDR_W-1:0]  tbl_next  [DEPTH];
   logic [rta_pkg::HOPS_W-1:0]  tbl_hops  [DEPTH];
   logic [rta_pkg::STAMP_W-1:0] tbl_stamp [DEPTH];
   logic [rta_pkg::SEQ_W-1:0]   tbl_seq   [DEPTH];
   int                          tbl_used;
   logic [rta_pkg::STAMP_W-1:0] tbl_time;
   logic [rta_pkg::STAMP_W-1:0] tbl_countdown;
   logic [15:0]                 cfg_life;
   logic [15:0]                 cfg_renew;

   route_rsp_type  awaited_rsp_q [$];
   dir_row_type    dir_rows [$];
   int             mismatch_count = 0;
   int             burst_left = 0;
   logic           rsp_hold = 1'b0;
   logic           hold_armed = 1'b0;
   rx_pattern_type rx_mode = RX_OPEN;
   int             rx_left = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic reset_route_model();
      for (int i = 0; i < DEPTH; i++) begin
         tbl_dest[i]  = '0;
         tbl_next[i]  = '0;
         tbl_hops[i]  = '0;
         tbl_stamp[i] = '0;
         tbl_seq[i]   = '0;
      end
      tbl_used      = 0;
      tbl_time      = '0;
      cfg_life      = rta_pkg::LIFE_LIMIT_RST;
      cfg_renew     = rta_pkg::RENEW_PERIOD_RST;
      tbl_countdown = rta_pkg::RENEW_PERIOD_RST;
   endtask

   function automatic route_rsp_type entry_report(int i);
      route_rsp_type r;
      r            = '0;
      r.found      = 1'b1;
      r.next_hop   = tbl_next[i];
      r.hop_len    = tbl_hops[i];
      r.stored_seq = tbl_seq[i];
      return r;
   endfunction

   // apply one command to the shadow table and return the response it gives
   function automatic route_rsp_type predict_route_rsp(route_req_type it);
      route_rsp_type               r;
      int                          lim;
      int                          hit;
      int                          slot;
      logic [rta_pkg::STAMP_W-1:0] age;
      r   = '0;
      hit = -1;
      lim = (tbl_used < DEPTH) ? tbl_used : DEPTH;
      case (it.command)
         rta_pkg::CMD_ADD: begin
            if (it.dst_node != '0) begin
               // find the first entry with the same destination and next hop
               for (int i = lim - 1; i >= 0; i--)
                  if (tbl_dest[i] == it.dst_node && tbl_next[i] == it.next_addr)
                     hit = i;
               if (hit >= 0) begin
                  // shorter path wins, the stored sequence stays
                  if (it.hops < tbl_hops[hit]) begin
                     tbl_hops[hit]  = it.hops;
                     tbl_stamp[hit] = tbl_time;
                  end
                  r = entry_report(hit);
               end else begin
                  // reuse the first cleared slot, else append, else drop
                  slot = -1;
                  for (int i = lim - 1; i >= 0; i--)
                     if (tbl_dest[i] == '0)
                        slot = i;
                  if (slot < 0) begin
                     if (tbl_used < DEPTH) begin
                        slot = tbl_used;
                        tbl_used++;
                     end else begin
                        r.full_drop = 1'b1;
                     end
                  end
                  if (slot >= 0) begin
                     tbl_dest[slot]  = it.dst_node;
                     tbl_next[slot]  = it.next_addr;
                     tbl_hops[slot]  = it.hops;
                     tbl_stamp[slot] = tbl_time;
                     tbl_seq[slot]   = it.route_seq;
                  end
               end
            end
         end
         rta_pkg::CMD_LOOKUP: begin
            if (it.dst_node != '0) begin
               for (int i = lim - 1; i >= 0; i--)
                  if (tbl_dest[i] == it.dst_node)
                     hit = i;
               if (hit >= 0)
                  r = entry_report(hit);
            end
         end
         rta_pkg::CMD_REFRESH: begin
            if (it.dst_node != '0)
               for (int i = 0; i < lim; i++)
                  if (tbl_dest[i] == it.dst_node)
                     tbl_stamp[i] = tbl_time;
         end
         default: begin
            // advance time; sweep out stale entries when the countdown runs out
            tbl_time = tbl_time + 16'd1;
            if (tbl_countdown <= 16'd1) begin
               tbl_countdown = (cfg_renew == '0) ? 16'd1 : cfg_renew;
               for (int i = 0; i < lim; i++) begin
                  age = tbl_time - tbl_stamp[i];
                  if (age > cfg_life) begin
                     tbl_dest[i]  = '0;
                     tbl_next[i]  = '0;
                     tbl_hops[i]  = '0;
                     tbl_stamp[i] = '0;
                     tbl_seq[i]   = '0;
                  end
               end
            end else begin
               tbl_countdown = tbl_countdown - 16'd1;
            end
         end
      endcase
      r.fill_level = tbl_used[rta_pkg::FILL_W-1:0];
      return r;
   endfunction

   function automatic route_req_type make_req(rta_pkg::cmd_type c, logic [15:0] d,
                                              logic [15:0] n, logic [15:0] h,
                                              logic [31:0] s);
      route_req_type it;
      it.command   = c;
      it.dst_node  = d;
      it.next_addr = n;
      it.hops      = h;
      it.route_seq = s;
      return it;
   endfunction

   function automatic route_rsp_type rsp_of(logic f, logic [15:0] nh, logic [15:0] hc,
                                            logic [31:0] ss, logic [5:0] fl, logic fd);
      route_rsp_type r;
      r.found      = f;
      r.next_hop   = nh;
      r.hop_len    = hc;
      r.stored_seq = ss;
      r.fill_level = fl;
      r.full_drop  = fd;
      return r;
   endfunction

   task automatic row_typed(rta_pkg::cmd_type c, logic [15:0] d, logic [15:0] n,
                            logic [15:0] h, logic [31:0] s, route_rsp_type r);
      dir_row_type row;
      row.req   = make_req(c, d, n, h, s);
      row.typed = 1'b1;
      row.rsp   = r;
      dir_rows.push_back(row);
   endtask

   task automatic row_pred(rta_pkg::cmd_type c, logic [15:0] d, logic [15:0] n,
                           logic [15:0] h, logic [31:0] s);
      dir_row_type row;
      row.req   = make_req(c, d, n, h, s);
      row.typed = 1'b0;
      row.rsp   = '0;
      dir_rows.push_back(row);
   endtask

   // offer one item, hold it until taken, then record what it should return
   task automatic send_route_req(route_req_type it, bit typed, route_rsp_type typed_rsp);
      route_rsp_type want;
      req_ch.valid     <= 1'b1;
      req_ch.command   <= it.command;
      req_ch.dst_node  <= it.dst_node;
      req_ch.next_addr <= it.next_addr;
      req_ch.hops      <= it.hops;
      req_ch.route_seq <= it.route_seq;
      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
      want = predict_route_rsp(it);
      awaited_rsp_q.push_back(typed ? typed_rsp : want);
   endtask

   // send in bursts with idle gaps in between
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 14);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
   endtask

   // stop sending and wait until every response is back
   task automatic await_all_rsp();
      req_ch.valid <= 1'b0;
      while (awaited_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(logic [rta_pkg::CSR_IDX_W-1:0] idx,
                            logic [rta_pkg::CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1)
         @(posedge clock);
      if (idx == rta_pkg::CSR_LIFE_LIMIT)
         cfg_life = data;
      else if (idx == rta_pkg::CSR_RENEW_PERIOD)
         cfg_renew = data;
   endtask

   task automatic apply_config(logic [15:0] life, logic [15:0] period, bit stray);
      await_all_rsp();
      write_csr(rta_pkg::CSR_LIFE_LIMIT, life);
      write_csr(rta_pkg::CSR_RENEW_PERIOD, period);
      if (stray)
         write_csr(($urandom_range(0, 1) != 0) ? CSR_SPARE_IDX : CSR_LAST_IDX,
                   16'($urandom_range(0, 16'hFFFF)));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly traffic on a small address pool so that routes collide, age and fill up
   task automatic run_random_phase(int n_items, int pool_n, int tick_pct);
      logic [rta_pkg::ADDR_W-1:0] dest_pool [$];
      logic [rta_pkg::ADDR_W-1:0] hop_pool [4];
      route_req_type              it;
      route_rsp_type              none;
      int                         roll;
      none = '0;
      for (int k = 0; k < pool_n; k++)
         dest_pool.push_back(16'($urandom_range(1, 16'hFFFF)));
      for (int k = 0; k < 4; k++)
         hop_pool[k] = 16'($urandom_range(0, 16'hFFFF));
      for (int k = 0; k < n_items; k++) begin
         roll         = $urandom_range(0, 99);
         it.dst_node  = dest_pool[$urandom_range(0, pool_n - 1)];
         it.next_addr = hop_pool[$urandom_range(0, 3)];
         it.hops      = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                    : 16'($urandom_range(0, 15));
         it.route_seq = $urandom;
         if (roll < 8) begin
            // noise: any command on any address, the reserved one included
            it.command   = rta_pkg::cmd_type'($urandom_range(0, 3));
            it.dst_node  = ($urandom_range(0, 3) == 0) ? '0
                                                       : 16'($urandom_range(0, 16'hFFFF));
            it.next_addr = 16'($urandom_range(0, 16'hFFFF));
         end else if (roll < 8 + tick_pct) begin
            it.command = rta_pkg::CMD_TICK;
         end else begin
            roll = $urandom_range(0, 5);
            it.command = (roll < 3) ? rta_pkg::CMD_ADD
                       : (roll < 5) ? rta_pkg::CMD_LOOKUP : rta_pkg::CMD_REFRESH;
         end
         pace_sender();
         send_route_req(it, 1'b0, none);
      end
   endtask

   // check each taken response and pick the next ready level
   always @(posedge clock) begin : rx_side
      route_rsp_type want;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_rsp_q.size() == 0) begin
            flag_mismatch("response with nothing awaited", '0, '0);
         end else begin
            want = awaited_rsp_q.pop_front();
            if (rsp_ch.found !== want.found)
               flag_mismatch("found", 32'(rsp_ch.found), 32'(want.found));
            if (rsp_ch.next_hop !== want.next_hop)
               flag_mismatch("next_hop", 32'(rsp_ch.next_hop), 32'(want.next_hop));
            if (rsp_ch.hop_len !== want.hop_len)
               flag_mismatch("hop_len", 32'(rsp_ch.hop_len), 32'(want.hop_len));
            if (rsp_ch.stored_seq !== want.stored_seq)
               flag_mismatch("stored_seq", rsp_ch.stored_seq, want.stored_seq);
            if (rsp_ch.fill_level !== want.fill_level)
               flag_mismatch("fill_level", 32'(rsp_ch.fill_level), 32'(want.fill_level));
            if (rsp_ch.full_drop !== want.full_drop)
               flag_mismatch("full_drop", 32'(rsp_ch.full_drop), 32'(want.full_drop));
         end
      end
      if (rx_left == 0) begin
         rx_mode = rx_pattern_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 240);
      end
      rx_left--;
      if (reset || rsp_hold) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ch.ready <= (rx_left % 4 == 0);
            default:   rsp_ch.ready <= ($urandom_range(0, 5) != 0);
         endcase
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (hold_armed === 1'b1);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("[route_table_with_aging_top] ERROR");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.command   = rta_pkg::CMD_ADD;
      req_ch.dst_node  = '0;
      req_ch.next_addr = '0;
      req_ch.hops      = '0;
      req_ch.route_seq = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.wdata     = '0;
      reset_route_model();

      // directed rows, register defaults after reset
      row_typed(rta_pkg::CMD_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 32'h0,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd0, 1'b0));
      row_typed(rta_pkg::CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 32'h0,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd0, 1'b0));
      row_typed(rta_pkg::CMD_ADD, 16'h0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd0, 1'b0));
      row_typed(rta_pkg::CMD_REFRESH, 16'h0000, 16'h0000, 16'h0000, 32'h0,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd0, 1'b0));
      row_typed(rta_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd0, 1'b0));
      row_typed(rta_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd1, 1'b0));
      row_typed(rta_pkg::CMD_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 32'h0,
                rsp_of(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 6'd1, 1'b0));
      // duplicate with a shorter path keeps the old sequence
      row_typed(rta_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'h0000, 32'h0,
                rsp_of(1'b1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 6'd1, 1'b0));
      row_pred(rta_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'h0001, 32'h0000_0001);
      row_typed(rta_pkg::CMD_ADD, 16'h0001, 16'h0000, 16'h0000, 32'h0,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd2, 1'b0));
      row_pred(rta_pkg::CMD_ADD, 16'hFFFF, 16'h0001, 16'h0003, 32'hA5A5_A5A5);
      row_pred(rta_pkg::CMD_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 32'h0);
      row_typed(rta_pkg::CMD_REFRESH, 16'hFFFF, 16'h0000, 16'h0000, 32'h0,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd3, 1'b0));
      row_pred(rta_pkg::CMD_ADD, 16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_5555);
      row_pred(rta_pkg::CMD_ADD, 16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_AAAA);
      row_pred(rta_pkg::CMD_LOOKUP, 16'hAAAA, 16'h0000, 16'h0000, 32'h0);
      row_pred(rta_pkg::CMD_LOOKUP, 16'h1234, 16'h0000, 16'h0000, 32'h0);
      row_typed(rta_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0,
                rsp_of(1'b0, 16'h0, 16'h0, 32'h0, 6'd5, 1'b0));
      row_pred(rta_pkg::CMD_REFRESH, 16'h5555, 16'h0000, 16'h0000, 32'h0);
      // equal hop count is not an improvement
      row_pred(rta_pkg::CMD_ADD, 16'h5555, 16'hAAAA, 16'h5555, 32'h0);
      row_pred(rta_pkg::CMD_LOOKUP, 16'h5555, 16'h0000, 16'h0000, 32'h0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         pace_sender();
         send_route_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);
      end

      // mixed traffic with long-lived entries and frequent sweeps
      apply_config(16'd100, 16'd7, 1'b0);
      run_random_phase(160, 10, 45);

      apply_config(16'd1, 16'd1, 1'b1);
      run_random_phase(110, 12, 30);

      // table fills and drops; the long receiver hold-off starts in this phase
      apply_config(16'hFFFF, 16'hFFFF, 1'b0);
      hold_armed <= 1'b1;
      run_random_phase(110, 48, 10);

      apply_config(16'd0, 16'd0, 1'b1);
      run_random_phase(110, 20, 25);

      apply_config(16'($urandom_range(5, 200)), 16'($urandom_range(1, 20)), 1'b0);
      run_random_phase(110, 40, 20);

      apply_config(16'd40, 16'd3, 1'b1);
      run_random_phase(110, 24, 20);

      apply_config(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                   1'b0);
      run_random_phase(110, 36, 15);

      apply_config(16'd8, 16'd2, 1'b0);
      run_random_phase(110, 16, 35);

      await_all_rsp();
      if (mismatch_count == 0)
         $display("[route_table_with_aging_top] OK");
      else
         $display("[route_table_with_aging_top] ERROR");
      $finish;
   end

endmodule
